// ===== design/rbst_pkg.sv =====
`default_nettype none

package rbst_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int LIMIT_W = 31;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + COORD_W;
  localparam int AXES    = 3;
  localparam int CFG_IDX_W = 3;

  localparam int LANE_LAT = 3;
  localparam int PIPE_LAT = LANE_LAT + 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ORIGIN_X  = 3'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y  = 3'd1;
  localparam cfg_idx_t CFG_ORIGIN_Z  = 3'd2;
  localparam cfg_idx_t CFG_INV_DIR_X = 3'd3;
  localparam cfg_idx_t CFG_INV_DIR_Y = 3'd4;
  localparam cfg_idx_t CFG_INV_DIR_Z = 3'd5;

  localparam coord_t ORIGIN_RST  = '0;
  localparam coord_t INV_DIR_RST = coord_t'(1 << FRAC_BITS);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

`default_nettype wire

// ===== design/rbst_if.sv =====
`default_nettype none

interface rbst_box_if;
  logic                 valid;
  logic                 ready;
  rbst_pkg::coord_t     lo_x;
  rbst_pkg::coord_t     lo_y;
  rbst_pkg::coord_t     lo_z;
  rbst_pkg::coord_t     hi_x;
  rbst_pkg::coord_t     hi_y;
  rbst_pkg::coord_t     hi_z;
  rbst_pkg::limit_t     dist_limit;

  modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, dist_limit,
                  input ready);
  modport sink (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, dist_limit,
                output ready);
endinterface

interface rbst_res_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// ===== design/rbst_slab_lane.sv =====
`default_nettype none

module rbst_slab_lane (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire rbst_pkg::coord_t corner,
  input  wire rbst_pkg::coord_t org,
  input  wire rbst_pkg::coord_t inv,
  output rbst_pkg::coord_t      t_r
);

  localparam int HI_LSB = rbst_pkg::COORD_W - 1 + rbst_pkg::FRAC_BITS;

  logic signed [rbst_pkg::DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [rbst_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [rbst_pkg::PROD_W-1-HI_LSB:0] prod_hi;
  rbst_pkg::coord_t                   t_nxt;

  assign diff_nxt = rbst_pkg::DIFF_W'(corner) - rbst_pkg::DIFF_W'(org);
  assign prod_nxt = rbst_pkg::PROD_W'(diff_r) * rbst_pkg::PROD_W'(inv);
  assign prod_hi  = prod_r[rbst_pkg::PROD_W-1:HI_LSB];

  // The arithmetic shift rounds toward minus infinity; the bits above the
  // 32-bit window must all equal its sign bit, otherwise the result saturates.
  always_comb begin
    if ((&prod_hi) || !(|prod_hi)) begin
      t_nxt = prod_r[HI_LSB:rbst_pkg::FRAC_BITS];
    end else if (prod_r[rbst_pkg::PROD_W-1]) begin
      t_nxt = rbst_pkg::COORD_MIN;
    end else begin
      t_nxt = rbst_pkg::COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      prod_r <= prod_nxt;
      t_r    <= t_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/ray_box_slab_test.sv =====
// Channel   Direction  Handshake     Payload
// in_box    sink       valid/ready   lo_x lo_y lo_z hi_x hi_y hi_z dist_limit
// out_res   source     valid/ready   hit
// cfg       write      cfg_we        cfg_index cfg_wdata
//
// One transaction is accepted per cycle while the pipeline is not held.
// The pipeline stages are the slab lanes (difference, product, saturation) followed
// by ordering, reduction to entry and exit distances, and the final compare.
// The whole pipeline holds when the output register is full and not taken.
// Reset is synchronous and active low; it clears the valid bits and origins and sets each inverse direction to one.
`default_nettype none

module ray_box_slab_test (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire rbst_pkg::cfg_idx_t   cfg_index,
  input  wire rbst_pkg::coord_t     cfg_wdata,
  rbst_box_if.sink                  in_box,
  rbst_res_if.source                out_res
);

  rbst_pkg::coord_t origin_r [rbst_pkg::AXES];
  rbst_pkg::coord_t inv_dir_r [rbst_pkg::AXES];

  logic                          adv;
  logic                          in_fire;
  logic [rbst_pkg::PIPE_LAT-1:0] vld_r, vld_nxt;

  rbst_pkg::coord_t lo [rbst_pkg::AXES];
  rbst_pkg::coord_t hi [rbst_pkg::AXES];
  rbst_pkg::coord_t t_lo [rbst_pkg::AXES];
  rbst_pkg::coord_t t_hi [rbst_pkg::AXES];
  rbst_pkg::limit_t lim_r [rbst_pkg::LANE_LAT+1];

  rbst_pkg::coord_t enter_a_r [rbst_pkg::AXES];
  rbst_pkg::coord_t leave_b_r [rbst_pkg::AXES];
  rbst_pkg::coord_t enter_r, enter_nxt;
  rbst_pkg::coord_t leave_r, leave_nxt;
  logic             hit_r, hit_nxt;

  assign adv     = !vld_r[rbst_pkg::PIPE_LAT-1] || out_res.ready;
  assign in_fire = in_box.valid && adv;
  assign vld_nxt = {vld_r[rbst_pkg::PIPE_LAT-2:0], in_box.valid};

  assign in_box.ready  = adv;
  assign out_res.valid = vld_r[rbst_pkg::PIPE_LAT-1];
  assign out_res.hit   = hit_r;

  assign lo[0] = in_box.lo_x;
  assign lo[1] = in_box.lo_y;
  assign lo[2] = in_box.lo_z;
  assign hi[0] = in_box.hi_x;
  assign hi[1] = in_box.hi_y;
  assign hi[2] = in_box.hi_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rbst_pkg::AXES; i++) begin
        origin_r[i]  <= rbst_pkg::ORIGIN_RST;
        inv_dir_r[i] <= rbst_pkg::INV_DIR_RST;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        rbst_pkg::CFG_ORIGIN_X:  origin_r[0]  <= cfg_wdata;
        rbst_pkg::CFG_ORIGIN_Y:  origin_r[1]  <= cfg_wdata;
        rbst_pkg::CFG_ORIGIN_Z:  origin_r[2]  <= cfg_wdata;
        rbst_pkg::CFG_INV_DIR_X: inv_dir_r[0] <= cfg_wdata;
        rbst_pkg::CFG_INV_DIR_Y: inv_dir_r[1] <= cfg_wdata;
        rbst_pkg::CFG_INV_DIR_Z: inv_dir_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar a = 0; a < rbst_pkg::AXES; a++) begin : g_axis
    rbst_slab_lane u_lo (
      .clk    (clk),
      .en     (adv),
      .corner (lo[a]),
      .org    (origin_r[a]),
      .inv    (inv_dir_r[a]),
      .t_r    (t_lo[a])
    );

    rbst_slab_lane u_hi (
      .clk    (clk),
      .en     (adv),
      .corner (hi[a]),
      .org    (origin_r[a]),
      .inv    (inv_dir_r[a]),
      .t_r    (t_hi[a])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        if (t_hi[a] < t_lo[a]) begin
          enter_a_r[a] <= t_hi[a];
          leave_b_r[a] <= t_lo[a];
        end else begin
          enter_a_r[a] <= t_lo[a];
          leave_b_r[a] <= t_hi[a];
        end
      end
    end
  end

  always_comb begin
    enter_nxt = '0;
    leave_nxt = rbst_pkg::coord_t'({1'b0, lim_r[rbst_pkg::LANE_LAT]});
    for (int i = 0; i < rbst_pkg::AXES; i++) begin
      if (enter_a_r[i] > enter_nxt) begin
        enter_nxt = enter_a_r[i];
      end
      if (leave_b_r[i] < leave_nxt) begin
        leave_nxt = leave_b_r[i];
      end
    end
  end

  assign hit_nxt = !(leave_r < enter_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      lim_r[0] <= in_box.dist_limit;
      for (int i = 1; i <= rbst_pkg::LANE_LAT; i++) begin
        lim_r[i] <= lim_r[i-1];
      end
      enter_r <= enter_nxt;
      leave_r <= leave_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // A held output freezes every stage of the pipeline.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  // An accepted transaction enters the first stage and the rest shift by one.
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> vld_r == {$past(vld_r[rbst_pkg::PIPE_LAT-2:0]), $past(in_fire)})
    else $error("pipeline valid bits did not advance correctly");

  // Reset empties the pipeline.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");

endmodule

`default_nettype wire
